### rtl/core/bzoa_pkg.sv
// Shared constants, types and reciprocal factors for the box zone occupancy alert unit.
package bzoa_pkg;

  localparam int REG_COUNT         = 6;
  localparam int ZONE_COUNT_DEF    = 6;
  localparam int FRACTION_BITS_DEF = 4;
  localparam int POINT_COUNT       = 5;
  localparam int MIN_INSIDE        = 3;
  localparam int COORD_W           = 16;
  localparam int PT_W              = 18;
  localparam int CFG_IDX_W         = 3;
  localparam int CFG_DATA_W        = 64;

  // floor(n / d) == (n * M) >> S, exact for every n below 2^N when
  // S = N + ceil(log2(d)) and M = ceil(2^S / d).
  localparam int S140 = 29;  // n < 2^21, d = 140
  localparam logic [21:0] M140 = 22'(((64'd1 << S140) + 64'd139) / 64'd140);
  localparam int S5A = 20;   // n = 2h < 2^17, d = 5
  localparam logic [17:0] M5A = 18'(((64'd1 << S5A) + 64'd4) / 64'd5);
  localparam int S10 = 22;   // n = 3h < 2^18, d = 10
  localparam logic [18:0] M10 = 19'(((64'd1 << S10) + 64'd9) / 64'd10);
  localparam int S5B = 19;   // n = h < 2^16, d = 5
  localparam logic [16:0] M5B = 17'(((64'd1 << S5B) + 64'd4) / 64'd5);

  typedef logic signed [PT_W-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } point_t;

  // Zone bounds in whole pixels, already ordered low/high.
  typedef struct packed {
    logic [COORD_W-1:0] xlo;
    logic [COORD_W-1:0] xhi;
    logic [COORD_W-1:0] ylo;
    logic [COORD_W-1:0] yhi;
  } zone_bounds_t;

  // Register reset values, index 0 in the low slot.
  localparam logic [REG_COUNT-1:0][CFG_DATA_W-1:0] ZONE_RESET = {
    64'd168887563049370250,
    64'd140739635875021350,
    64'd112591708700672450,
    64'd84443781526323550,
    64'd56295854351974650,
    64'd28147927177625750
  };

endpackage

### rtl/core/bzoa_zone_regs.sv
// Zone rectangle register file; bounds are ordered low/high as they are written.
module bzoa_zone_regs (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_wr,
  input  logic [bzoa_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [bzoa_pkg::CFG_DATA_W-1:0]       cfg_data,
  output bzoa_pkg::zone_bounds_t                zones [bzoa_pkg::REG_COUNT]
);

  function automatic bzoa_pkg::zone_bounds_t order_bounds(
    input logic [bzoa_pkg::CFG_DATA_W-1:0] raw
  );
    logic [15:0] xa, ya, xb, yb;
    bzoa_pkg::zone_bounds_t b;
    xa = raw[63:48];
    ya = raw[47:32];
    xb = raw[31:16];
    yb = raw[15:0];
    b.xlo = (xa < xb) ? xa : xb;
    b.xhi = (xa < xb) ? xb : xa;
    b.ylo = (ya < yb) ? ya : yb;
    b.yhi = (ya < yb) ? yb : ya;
    return b;
  endfunction

  bzoa_pkg::zone_bounds_t wr_bounds;
  assign wr_bounds = order_bounds(cfg_data);

  always_ff @(posedge clk) begin
    for (int i = 0; i < bzoa_pkg::REG_COUNT; i++) begin
      if (rst) begin
        zones[i] <= order_bounds(bzoa_pkg::ZONE_RESET[i]);
      end else if (cfg_wr && cfg_index == bzoa_pkg::CFG_IDX_W'(i)) begin
        zones[i] <= wr_bounds;
      end
    end
  end

endmodule

### rtl/core/bzoa_point_gen.sv
// Five sample points of a box, using reciprocal multiplies for the constant divides.
module bzoa_point_gen (
  input  logic [bzoa_pkg::COORD_W-1:0] x,
  input  logic [bzoa_pkg::COORD_W-1:0] y,
  input  logic [bzoa_pkg::COORD_W-1:0] w,
  input  logic [bzoa_pkg::COORD_W-1:0] h,
  output bzoa_pkg::point_t             pts [bzoa_pkg::POINT_COUNT]
);

  logic [14:0] w_q_ceil;   // ceil(w/4)
  logic [13:0] w_q;        // floor(w/4)
  logic [20:0] n19;        // 19w + 139, so the divide rounds up
  logic [20:0] n27;
  logic [42:0] p19, p27;
  logic [13:0] q19, q27;
  logic [16:0] n2h;
  logic [17:0] n3h;
  logic [34:0] p2h;
  logic [36:0] p3h;
  logic [32:0] ph;
  logic [14:0] q2h5, q3h10;
  logic [13:0] qh5;
  bzoa_pkg::coord_t xs, ys;

  assign w_q_ceil = 15'((17'(w) + 17'd3) >> 2);
  assign w_q      = w[15:2];

  assign n19 = 21'(21'(w) * 21'd19 + 21'd139);
  assign n27 = 21'(21'(w) * 21'd27);
  assign p19 = 43'(n19) * 43'(bzoa_pkg::M140);
  assign p27 = 43'(n27) * 43'(bzoa_pkg::M140);
  assign q19 = p19[bzoa_pkg::S140 +: 14];
  assign q27 = p27[bzoa_pkg::S140 +: 14];

  assign n2h   = {h, 1'b0};
  assign n3h   = 18'(18'(h) * 18'd3);
  assign p2h   = 35'(n2h) * 35'(bzoa_pkg::M5A);
  assign p3h   = 37'(n3h) * 37'(bzoa_pkg::M10);
  assign ph    = 33'(h) * 33'(bzoa_pkg::M5B);
  assign q2h5  = p2h[bzoa_pkg::S5A +: 15];
  assign q3h10 = p3h[bzoa_pkg::S10 +: 15];
  assign qh5   = ph[bzoa_pkg::S5B +: 14];

  assign xs = bzoa_pkg::coord_t'(x);
  assign ys = bzoa_pkg::coord_t'(y);

  // x offsets -w/4, 0, +w/4, -19w/140, +27w/140 (floor); y offsets 2h/5, 3h/10, h/5
  assign pts[0].x = xs - bzoa_pkg::coord_t'(w_q_ceil);
  assign pts[1].x = xs;
  assign pts[2].x = xs + bzoa_pkg::coord_t'(w_q);
  assign pts[3].x = xs - bzoa_pkg::coord_t'(q19);
  assign pts[4].x = xs + bzoa_pkg::coord_t'(q27);

  assign pts[0].y = ys + bzoa_pkg::coord_t'(q2h5);
  assign pts[1].y = ys + bzoa_pkg::coord_t'(q3h10);
  assign pts[2].y = ys + bzoa_pkg::coord_t'(qh5);
  assign pts[3].y = ys + bzoa_pkg::coord_t'(qh5);
  assign pts[4].y = ys + bzoa_pkg::coord_t'(q2h5);

endmodule

### rtl/core/bzoa_zone_test.sv
// Strict-inside test of five points against one zone, hit on three or more.
module bzoa_zone_test #(
  parameter int FRACTION_BITS = bzoa_pkg::FRACTION_BITS_DEF
) (
  input  bzoa_pkg::point_t       pts [bzoa_pkg::POINT_COUNT],
  input  bzoa_pkg::zone_bounds_t zone,
  output logic                   hit
);

  localparam int CW = bzoa_pkg::COORD_W + FRACTION_BITS + 2;

  logic signed [CW-1:0] xlo, xhi, ylo, yhi;
  logic [bzoa_pkg::POINT_COUNT-1:0] in_zone;
  logic [2:0] count;

  assign xlo = signed'(CW'(zone.xlo) << FRACTION_BITS);
  assign xhi = signed'(CW'(zone.xhi) << FRACTION_BITS);
  assign ylo = signed'(CW'(zone.ylo) << FRACTION_BITS);
  assign yhi = signed'(CW'(zone.yhi) << FRACTION_BITS);

  always_comb begin
    for (int i = 0; i < bzoa_pkg::POINT_COUNT; i++) begin
      in_zone[i] = (CW'(pts[i].x) > xlo) && (CW'(pts[i].x) < xhi) &&
                   (CW'(pts[i].y) > ylo) && (CW'(pts[i].y) < yhi);
    end
  end

  always_comb begin
    count = '0;
    for (int i = 0; i < bzoa_pkg::POINT_COUNT; i++) begin
      count = count + 3'(in_zone[i]);
    end
  end

  assign hit = count >= 3'(bzoa_pkg::MIN_INSIDE);

endmodule

### rtl/core/box_zone_occupancy_alert_unit.sv
// Top level: per-box zone occupancy test with per-frame sticky alerts.
//
// One detection box is taken per cycle while no frame_last item waits on the
// output. A transfer on the input channel passes through two register
// stages: the first forms the five sample points (constant divides done as
// reciprocal multiplies), the second tests them against all zones in
// parallel and folds the hits into the per-frame flags. A frame's result is
// registered as its frame_last item leaves the second stage and sits in an
// output register until taken; input transfers keep flowing behind it as
// long as only items without frame_last are in flight. Zone registers may be
// written at any time the unit is idle; cfg_ready is always high and indices
// six and seven are ignored.
module box_zone_occupancy_alert_unit #(
  parameter int ZONE_COUNT    = bzoa_pkg::ZONE_COUNT_DEF,
  parameter int FRACTION_BITS = bzoa_pkg::FRACTION_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bzoa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bzoa_pkg::CFG_DATA_W-1:0]     cfg_data,
  // box input channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                box_present,
  input  logic [bzoa_pkg::COORD_W-1:0]        center_x,
  input  logic [bzoa_pkg::COORD_W-1:0]        center_y,
  input  logic [bzoa_pkg::COORD_W-1:0]        box_width,
  input  logic [bzoa_pkg::COORD_W-1:0]        box_height,
  input  logic                                frame_last,
  // frame result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                alert_enemy_buff,
  output logic                                alert_enemy_snipe,
  output logic                                alert_enemy_slope,
  output logic                                alert_self_outpost,
  output logic                                alert_self_sentry,
  output logic                                alert_self_base,
  output logic                                empty_frame
);

  localparam int RC = bzoa_pkg::REG_COUNT;

  // ---------------- configuration ----------------
  bzoa_pkg::zone_bounds_t zones [RC];

  assign cfg_ready = 1'b1;

  bzoa_zone_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .zones     (zones)
  );

  // ---------------- pipeline control ----------------
  logic a_valid, b_valid;
  logic a_fire, b_fire, o_free, b_ready;
  logic b_last, b_present;

  assign o_free   = !out_valid || out_ready;
  // only the frame's last item needs the output slot
  assign b_fire   = b_valid && (!b_last || o_free);
  assign b_ready  = !b_valid || b_fire;
  assign a_fire   = a_valid && b_ready;
  assign in_ready = !a_valid || a_fire;

  // ---------------- stage A: captured box ----------------
  logic                         a_present, a_last;
  logic [bzoa_pkg::COORD_W-1:0] a_x, a_y, a_w, a_h;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_ready) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      a_present <= box_present;
      a_last    <= frame_last;
      a_x       <= center_x;
      a_y       <= center_y;
      a_w       <= box_width;
      a_h       <= box_height;
    end
  end

  // ---------------- stage B: sample points ----------------
  bzoa_pkg::point_t a_pts [bzoa_pkg::POINT_COUNT];
  bzoa_pkg::point_t b_pts [bzoa_pkg::POINT_COUNT];

  bzoa_point_gen u_points (
    .x   (a_x),
    .y   (a_y),
    .w   (a_w),
    .h   (a_h),
    .pts (a_pts)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_ready) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_fire) begin
      b_present <= a_present;
      b_last    <= a_last;
      b_pts     <= a_pts;
    end
  end

  // ---------------- zone tests ----------------
  logic [RC-1:0] zone_hit;

  for (genvar z = 0; z < RC; z++) begin : g_zone
    if (z < ZONE_COUNT) begin : g_on
      bzoa_zone_test #(
        .FRACTION_BITS (FRACTION_BITS)
      ) u_test (
        .pts  (b_pts),
        .zone (zones[z]),
        .hit  (zone_hit[z])
      );
    end else begin : g_off
      assign zone_hit[z] = 1'b0;  // zone not built
    end
  end

  // ---------------- frame state and result ----------------
  logic [RC-1:0] zone_hits, zone_hits_next;
  logic          box_seen, box_seen_next;
  logic [RC-1:0] alerts;
  logic          empty_reg;

  // marker items contribute nothing
  assign zone_hits_next = zone_hits | (b_present ? zone_hit : '0);
  assign box_seen_next  = box_seen || b_present;

  always_ff @(posedge clk) begin
    if (rst) begin
      zone_hits <= '0;
      box_seen  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (b_fire) begin
        if (b_last) begin
          zone_hits <= '0;
          box_seen  <= 1'b0;
        end else begin
          zone_hits <= zone_hits_next;
          box_seen  <= box_seen_next;
        end
      end
      if (b_fire && b_last) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (b_fire && b_last) begin
      alerts    <= zone_hits_next;
      empty_reg <= !box_seen_next;
    end
  end

  assign alert_enemy_buff   = alerts[0];
  assign alert_enemy_snipe  = alerts[1];
  assign alert_enemy_slope  = alerts[2];
  assign alert_self_outpost = alerts[3];
  assign alert_self_sentry  = alerts[4];
  assign alert_self_base    = alerts[5];
  assign empty_frame        = empty_reg;

  // ---------------- assertions ----------------
  // a zone can only be flagged by a box, so no box means no flags
  a_hits_need_box: assert property (@(posedge clk) disable iff (rst)
    !box_seen |-> zone_hits == '0)
    else $error("zone flag set without any box in the frame");

  // closing a frame clears the frame state and raises a result
  a_frame_close: assert property (@(posedge clk) disable iff (rst)
    b_fire && b_last |=> out_valid && zone_hits == '0 && !box_seen)
    else $error("frame close did not clear state or present a result");

  // an empty frame carries no alerts
  a_empty_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && empty_frame |-> alerts == '0)
    else $error("empty frame reported with an alert set");

endmodule

### test/box_zone_occupancy_alert_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the box zone occupancy alert unit.
module box_zone_occupancy_alert_unit_tb;

  localparam int CLK_HALF        = 4;
  localparam int RESET_CYCLES    = 10;
  // leave margin for the result to be registered after the closing transfer
  localparam int SETTLE_CYCLES   = 8;
  // honest quiet stretches come from receiver stalls and sender gaps, both
  // drawn from short random ranges, so this is far beyond any correct run
  localparam int QUIET_LIMIT     = 2000;
  localparam int RANDOM_PHASES   = 6;
  localparam int BOXES_PER_PHASE = 85;
  localparam int FRAC            = bzoa_pkg::FRACTION_BITS_DEF;
  localparam int ZONES           = bzoa_pkg::ZONE_COUNT_DEF;
  localparam int NREGS           = bzoa_pkg::REG_COUNT;
  localparam int CFG_SLOTS       = 1 << bzoa_pkg::CFG_IDX_W;
  localparam int MIN_PTS         = 3;
  localparam int QMAX            = 65535;

  // Sample point taps, five points, one byte each (point 0 in the low byte).
  // x offset = tap/140 of the width from the left edge,
  // y offset = tap/10 of the height up from the bottom edge.
  localparam logic [39:0] X_TAPS = {8'd97, 8'd51, 8'd105, 8'd70, 8'd35};
  localparam logic [39:0] Y_TAPS = {8'd1, 8'd3, 8'd3, 8'd2, 8'd1};

  typedef enum logic [bzoa_pkg::CFG_IDX_W-1:0] {
    REG_ENEMY_BUFF,
    REG_ENEMY_SNIPE,
    REG_ENEMY_SLOPE,
    REG_SELF_OUTPOST,
    REG_SELF_SENTRY,
    REG_SELF_BASE
  } zone_reg_e;

  typedef enum int {RX_OPEN, RX_CHOPPY, RX_BLOCKED} rx_mode_e;

  typedef logic [bzoa_pkg::CFG_DATA_W-1:0] zone_word_t;
  typedef logic [NREGS-1:0][bzoa_pkg::CFG_DATA_W-1:0] zone_set_t;

  typedef struct packed {
    logic                          present;
    logic [bzoa_pkg::COORD_W-1:0]  cx;
    logic [bzoa_pkg::COORD_W-1:0]  cy;
    logic [bzoa_pkg::COORD_W-1:0]  bw;
    logic [bzoa_pkg::COORD_W-1:0]  bh;
    logic                          last;
  } box_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                              cfg_valid = 1'b0;
  logic                              cfg_ready;
  logic [bzoa_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
  logic [bzoa_pkg::CFG_DATA_W-1:0]   cfg_data  = '0;

  logic                              in_valid    = 1'b0;
  logic                              in_ready;
  logic                              box_present = 1'b0;
  logic [bzoa_pkg::COORD_W-1:0]      center_x    = '0;
  logic [bzoa_pkg::COORD_W-1:0]      center_y    = '0;
  logic [bzoa_pkg::COORD_W-1:0]      box_width   = '0;
  logic [bzoa_pkg::COORD_W-1:0]      box_height  = '0;
  logic                              frame_last  = 1'b0;

  logic out_valid;
  logic out_ready = 1'b0;
  logic alert_enemy_buff, alert_enemy_snipe, alert_enemy_slope;
  logic alert_self_outpost, alert_self_sentry, alert_self_base;
  logic empty_frame;

  // Shadow of the zone registers and the frame being built.
  zone_set_t   zone_regs;
  logic [5:0]  frame_hits    = '0;
  logic        frame_has_box = 1'b0;
  // Expected frame results: bit z is zone z's alert, bit 6 is empty_frame.
  logic [6:0]  pending_alerts[$];

  int       mismatches   = 0;
  int       burst_left   = 0;
  int       quiet_cycles = 0;
  int       rx_left      = 0;
  rx_mode_e rx_mode      = RX_OPEN;

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  box_zone_occupancy_alert_unit u_top (
    .clk                (clk),
    .rst                (rst),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .box_present        (box_present),
    .center_x           (center_x),
    .center_y           (center_y),
    .box_width          (box_width),
    .box_height         (box_height),
    .frame_last         (frame_last),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .alert_enemy_buff   (alert_enemy_buff),
    .alert_enemy_snipe  (alert_enemy_snipe),
    .alert_enemy_slope  (alert_enemy_slope),
    .alert_self_outpost (alert_self_outpost),
    .alert_self_sentry  (alert_self_sentry),
    .alert_self_base    (alert_self_base),
    .empty_frame        (empty_frame)
  );

  // ---------------------------------------------------------------------
  // Small helpers
  // ---------------------------------------------------------------------

  // whole pixels to Q12.4
  function automatic logic [15:0] pix(int p);
    return 16'(p << FRAC);
  endfunction

  // register word: x_min, y_min, x_max, y_max in whole pixels
  function automatic zone_word_t zone_rect(int xmin, int ymin, int xmax, int ymax);
    return {16'(xmin), 16'(ymin), 16'(xmax), 16'(ymax)};
  endfunction

  function automatic zone_set_t reset_zones();
    zone_set_t s;
    for (int z = 0; z < NREGS; z++) begin
      s[z] = zone_rect(100 * (z + 1), 100 * (z + 1), 100 * (z + 1) + 50, 100 * (z + 1) + 50);
    end
    return s;
  endfunction

  function automatic box_item_t make_box(logic present, logic [15:0] x, logic [15:0] y,
                                         logic [15:0] w, logic [15:0] h, logic last);
    box_item_t b;
    b.present = present;
    b.cx      = x;
    b.cy      = y;
    b.bw      = w;
    b.bh      = h;
    b.last    = last;
    return b;
  endfunction

  function automatic string alert_name(int i);
    case (i)
      0:       return "alert_enemy_buff";
      1:       return "alert_enemy_snipe";
      2:       return "alert_enemy_slope";
      3:       return "alert_self_outpost";
      4:       return "alert_self_sentry";
      5:       return "alert_self_base";
      default: return "empty_frame";
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Occupancy predictor
  // ---------------------------------------------------------------------

  // division rounded toward minus infinity
  function automatic longint floor_div(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q = q - 1;
    return q;
  endfunction

  function automatic longint bound_q(logic [15:0] v);
    longint r;
    r = v;
    return r << FRAC;
  endfunction

  // Zones holding at least three of the box's five sample points.
  function automatic logic [5:0] box_zone_hits(box_item_t b);
    longint x, y, w, h, kx, ky, px, py, xa, xb, ya, yb, xlo, xhi, ylo, yhi;
    int in_count;
    logic [5:0] hits;
    x = b.cx;
    y = b.cy;
    w = b.bw;
    h = b.bh;
    hits = '0;
    for (int z = 0; z < ZONES; z++) begin
      xa  = bound_q(zone_regs[z][63:48]);
      ya  = bound_q(zone_regs[z][47:32]);
      xb  = bound_q(zone_regs[z][31:16]);
      yb  = bound_q(zone_regs[z][15:0]);
      // bounds may come swapped; equal bounds leave nothing strictly inside
      xlo = (xa < xb) ? xa : xb;
      xhi = (xa < xb) ? xb : xa;
      ylo = (ya < yb) ? ya : yb;
      yhi = (ya < yb) ? yb : ya;
      in_count = 0;
      for (int p = 0; p < 5; p++) begin
        kx = X_TAPS[8*p +: 8];
        ky = Y_TAPS[8*p +: 8];
        // left = x - w/2, bottom = y + h/2, one truncation per coordinate
        px = floor_div(140 * x - 70 * w + kx * w, 140);
        py = floor_div(10 * y + 5 * h - ky * h, 10);
        if (px > xlo && px < xhi && py > ylo && py < yhi) in_count++;
      end
      if (in_count >= MIN_PTS) hits[z] = 1'b1;
    end
    return hits;
  endfunction

  // Called once per accepted input transfer.
  function automatic void fold_box_into_frame(box_item_t b);
    if (b.present) begin
      frame_hits    = frame_hits | box_zone_hits(b);
      frame_has_box = 1'b1;
    end
    if (b.last) begin
      pending_alerts.push_back({~frame_has_box, frame_hits});
      frame_hits    = '0;
      frame_has_box = 1'b0;
    end
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus generators
  // ---------------------------------------------------------------------

  function automatic logic [15:0] pick_coord(int lo, int hi);
    if (lo < 0) lo = 0;
    if (hi < 0) hi = 0;
    if (lo > QMAX) lo = QMAX;
    if (hi > QMAX) hi = QMAX;
    if (lo > hi) lo = hi;
    return 16'($urandom_range(lo, hi));
  endfunction

  // Box placed so its sample points land on or near zone z.
  function automatic box_item_t aimed_box(int z);
    box_item_t b;
    int xa, xb, ya, yb, xlo, xhi, ylo, yhi, rise;
    xa  = int'(zone_regs[z][63:48]) << FRAC;
    ya  = int'(zone_regs[z][47:32]) << FRAC;
    xb  = int'(zone_regs[z][31:16]) << FRAC;
    yb  = int'(zone_regs[z][15:0]) << FRAC;
    xlo = (xa < xb) ? xa : xb;
    xhi = (xa < xb) ? xb : xa;
    ylo = (ya < yb) ? ya : yb;
    yhi = (ya < yb) ? yb : ya;
    b.present = 1'b1;
    b.last    = 1'b0;
    b.bw      = pick_coord(0, (xhi - xlo) * 2 + 32);
    b.cx      = pick_coord(xlo - 48, xhi + 48);
    b.bh      = pick_coord(0, (yhi - ylo) * 2 + 32);
    // points sit 0.2h to 0.4h below the center in image rows
    rise      = b.bh;
    rise      = rise * 3 / 10;
    b.cy      = pick_coord(ylo - rise - 48, yhi - rise + 48);
    return b;
  endfunction

  function automatic box_item_t noise_box(logic present);
    return make_box(present, 16'($urandom), 16'($urandom), 16'($urandom),
                    16'($urandom), 1'b0);
  endfunction

  function automatic zone_set_t random_zone_set();
    zone_set_t s;
    int x0, y0, x1, y1, tmp;
    for (int z = 0; z < NREGS; z++) begin
      case ($urandom_range(0, 9))
        0: s[z] = {$urandom, $urandom};
        1: begin
          // degenerate: one axis collapsed
          x0 = $urandom_range(0, 4000);
          y0 = $urandom_range(0, 4000);
          s[z] = ($urandom_range(0, 1) == 1) ? zone_rect(x0, y0, x0, y0 + 100)
                                             : zone_rect(x0, y0, x0 + 100, y0);
        end
        2: s[z] = zone_rect($urandom_range(0, 4095), $urandom_range(0, 4095),
                            $urandom_range(0, 4095), $urandom_range(0, 4095));
        default: begin
          x0 = $urandom_range(0, 3800);
          y0 = $urandom_range(0, 3800);
          x1 = x0 + $urandom_range(10, 400);
          y1 = y0 + $urandom_range(10, 400);
          if ($urandom_range(0, 1) == 1) begin
            tmp = x0; x0 = x1; x1 = tmp;
          end
          if ($urandom_range(0, 1) == 1) begin
            tmp = y0; y0 = y1; y1 = tmp;
          end
          s[z] = zone_rect(x0, y0, x1, y1);
        end
      endcase
    end
    return s;
  endfunction

  // ---------------------------------------------------------------------
  // Channel drivers
  // ---------------------------------------------------------------------

  // One input transfer. The sender runs in bursts; between bursts valid
  // drops for a random gap. Prediction happens at the accepting edge.
  task automatic send_box(input box_item_t b);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 12);
    end
    in_valid    <= 1'b1;
    box_present <= b.present;
    center_x    <= b.cx;
    center_y    <= b.cy;
    box_width   <= b.bw;
    box_height  <= b.bh;
    frame_last  <= b.last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
    fold_box_into_frame(b);
  endtask

  // Writes every slot of the index space; the two spare slots get junk
  // that the unit must ignore. Valid stays up across the writes.
  task automatic load_zones(input zone_set_t s);
    for (int i = 0; i < CFG_SLOTS; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= bzoa_pkg::CFG_IDX_W'(i);
      cfg_data  <= (i < NREGS) ? s[i] : {$urandom, $urandom};
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      if (i < NREGS) zone_regs[i] = s[i];
    end
    cfg_valid <= 1'b0;
  endtask

  // Stop sending, wait for every expected frame result, then let the
  // pipeline settle so the unit is idle for a register write.
  task automatic drain_frames();
    in_valid   <= 1'b0;
    burst_left = 0;
    while (pending_alerts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Zones at their reset values.
  task automatic test_reset_zones();
    // point boxes in the centers of the first and last zone
    send_box(make_box(1'b1, pix(125), pix(125), '0, '0, 1'b0));
    send_box(make_box(1'b1, pix(625), pix(625), '0, '0, 1'b1));
    // frame made of a lone marker
    send_box(make_box(1'b0, '0, '0, '0, '0, 1'b1));
    // junk behind a marker must be ignored; point on the left edge misses
    send_box(make_box(1'b0, '1, '1, '1, '1, 1'b0));
    send_box(make_box(1'b1, pix(200), pix(225), '0, '0, 1'b1));
    // one step inside the corner
    send_box(make_box(1'b1, pix(200) + 16'd1, pix(250) - 16'd1, '0, '0, 1'b1));
    // three points left of the right edge: hit
    send_box(make_box(1'b1, pix(350) - 16'd10, pix(325), 16'd200, '0, 1'b1));
    // center on the right edge leaves two points inside: no hit
    send_box(make_box(1'b1, pix(350), pix(325), 16'd200, '0, 1'b1));
    // field extremes, frame closed by a junk marker
    send_box(make_box(1'b1, '1, '1, '1, '1, 1'b0));
    send_box(make_box(1'b1, '0, '0, '0, '0, 1'b0));
    send_box(make_box(1'b0, '1, '1, '1, '1, 1'b1));
    // one box per zone, all six alerts in one frame
    for (int z = 0; z < ZONES; z++) begin
      send_box(make_box(1'b1, pix(100 * (z + 1) + 25), pix(100 * (z + 1) + 10),
                        pix(20), pix(20), z == ZONES - 1));
    end
    drain_frames();
  endtask

  // Swapped, collapsed, full-range and all-zero/all-one zone words.
  task automatic test_zone_edits();
    zone_set_t s;
    s = reset_zones();
    s[REG_ENEMY_BUFF]   = zone_rect(150, 150, 100, 100);
    s[REG_ENEMY_SNIPE]  = zone_rect(225, 200, 225, 250);
    s[REG_ENEMY_SLOPE]  = zone_rect(0, 0, QMAX, QMAX);
    s[REG_SELF_OUTPOST] = '0;
    s[REG_SELF_SENTRY]  = '1;
    s[REG_SELF_BASE]    = zone_rect(600, 650, 650, 600);
    load_zones(s);
    send_box(make_box(1'b1, pix(125), pix(125), '0, '0, 1'b0));
    send_box(make_box(1'b1, pix(225), pix(225), '0, '0, 1'b0));
    send_box(make_box(1'b1, pix(625), pix(625), pix(10), pix(10), 1'b0));
    send_box(make_box(1'b1, 16'd1, 16'd1, '0, '0, 1'b1));
    // left edge far below zero, then the largest box
    send_box(make_box(1'b1, '0, '0, '1, '1, 1'b0));
    send_box(make_box(1'b1, '1, '1, '1, '1, 1'b1));
    send_box(make_box(1'b0, '0, '0, '0, '0, 1'b1));
    drain_frames();
  endtask

  // Random zone layouts; frames mostly of boxes aimed at zones, with
  // markers, marker-only frames and raw noise mixed in.
  task automatic test_random_traffic();
    box_item_t b;
    int boxes, frame_len, pick;
    bit markers_only;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      load_zones((phase == RANDOM_PHASES - 1) ? reset_zones() : random_zone_set());
      boxes = 0;
      while (boxes < BOXES_PER_PHASE) begin
        frame_len    = ($urandom_range(0, 19) == 0) ? $urandom_range(8, 20)
                                                    : $urandom_range(1, 5);
        markers_only = ($urandom_range(0, 19) == 0);
        for (int k = 0; k < frame_len; k++) begin
          pick = $urandom_range(0, 99);
          if (markers_only || pick < 8) b = noise_box(1'b0);
          else if (pick < 25)           b = noise_box(1'b1);
          else                          b = aimed_box($urandom_range(0, ZONES - 1));
          b.last = (k == frame_len - 1);
          send_box(b);
          if (b.present) boxes++;
        end
      end
      drain_frames();
    end
  endtask

  // ---------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------

  // Receiver backpressure: open stretches, choppy stretches and solid
  // stalls, chosen at random.
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 2));
      rx_left = (rx_mode == RX_BLOCKED) ? $urandom_range(2, 24) : $urandom_range(4, 40);
    end
    rx_left--;
    case (rx_mode)
      RX_OPEN:    out_ready <= 1'b1;
      RX_CHOPPY:  out_ready <= 1'($urandom_range(0, 1));
      default:    out_ready <= 1'b0;
    endcase
  end

  // Each result transfer against the oldest expected frame.
  always @(posedge clk) begin : check_alerts
    logic [6:0] got, want;
    if (!rst && out_valid && out_ready) begin
      got = {empty_frame, alert_self_base, alert_self_sentry, alert_self_outpost,
             alert_enemy_slope, alert_enemy_snipe, alert_enemy_buff};
      if (pending_alerts.size() == 0) begin
        $error("frame result with none expected: %b", got);
        mismatches++;
      end else begin
        want = pending_alerts.pop_front();
        for (int i = 0; i < 7; i++) begin
          if (got[i] !== want[i]) begin
            $error("%s: expected %0d, got %0d", alert_name(i), want[i], got[i]);
            mismatches++;
          end
        end
      end
    end
  end

  // Watchdog: any transfer on any channel counts as progress.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("box_zone_occupancy_alert_unit_tb: done, errors");
      $finish;
    end
  end

  initial begin
    zone_regs = reset_zones();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_zones();
    test_zone_edits();
    test_random_traffic();
    drain_frames();
    if (mismatches == 0 && pending_alerts.size() == 0) begin
      $display("box_zone_occupancy_alert_unit_tb: done, clean");
    end else begin
      $display("box_zone_occupancy_alert_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
